// ===== rtl/core/tbt_pkg.sv =====
// Shared types and character constants for the template block translator.
`timescale 1ns / 1ps

package tbt_pkg;

   // Longest output burst of one request: end of document in text mode with
   // three held tag bytes and no open run: wrapper open, held tag, wrapper close.
   localparam int BUF_BYTES = 14;
   localparam int BUF_W     = 8 * BUF_BYTES;
   localparam int CNT_W     = 4;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_QM     = 8'h3F;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   // Byte strings packed with the first character in the lowest byte.
   localparam logic [55:0] WRAP_OPEN  = {8'h22, 8'h28, 8'h74, 8'h6E, 8'h69, 8'h72, 8'h70};
   localparam logic [31:0] WRAP_CLOSE = {8'h0A, 8'h3B, 8'h29, 8'h22};
   localparam logic [CNT_W-1:0] WRAP_OPEN_LEN  = 4'd7;
   localparam logic [CNT_W-1:0] WRAP_CLOSE_LEN = 4'd4;

   typedef struct packed {
      logic       in_code;
      logic [1:0] tag_len;
      logic       held_q;
      logic       seg_open;
   } tbt_state_type;

   typedef struct packed {
      logic [BUF_W-1:0] bytes;
      logic [CNT_W-1:0] count;
   } tbt_emit_type;

endpackage

// ===== rtl/core/tbt_xlate.sv =====
// Translation of one request: next mode state and the packed output burst.
`timescale 1ns / 1ps

module tbt_xlate (
   input  tbt_pkg::tbt_state_type cur,
   input  logic                   kind,
   input  logic [7:0]             data,
   output tbt_pkg::tbt_state_type nxt,
   output tbt_pkg::tbt_emit_type  emit
);
   import tbt_pkg::*;

   function automatic logic [7:0] tag_char(input logic [1:0] idx);
      case (idx)
         2'd0:    tag_char = CH_LT;
         2'd1:    tag_char = CH_QM;
         2'd2:    tag_char = CH_L;
         default: tag_char = CH_X;
      endcase
   endfunction

   // Held prefix of the opening tag, first byte lowest.
   function automatic logic [23:0] tag_bytes(input logic [1:0] len);
      case (len)
         2'd1:    tag_bytes = {16'h0000, CH_LT};
         2'd2:    tag_bytes = {8'h00, CH_QM, CH_LT};
         2'd3:    tag_bytes = {CH_L, CH_QM, CH_LT};
         default: tag_bytes = 24'h000000;
      endcase
   endfunction

   logic             need_open;
   logic             need_close;
   logic [1:0]       tag_n;
   logic [15:0]      ch_seg;
   logic [1:0]       ch_n;
   logic             is_lt;
   logic [BUF_W-1:0] acc;
   logic [CNT_W-1:0] pos;

   always_comb begin
      nxt        = cur;
      need_open  = 1'b0;
      need_close = 1'b0;
      tag_n      = 2'd0;
      ch_seg     = 16'h0000;
      ch_n       = 2'd0;
      is_lt      = (data == CH_LT);

      if (kind) begin
         if (cur.in_code) begin
            if (cur.held_q) begin
               ch_seg = {CH_LF, CH_QM};
               ch_n   = 2'd2;
            end else begin
               ch_seg = {8'h00, CH_LF};
               ch_n   = 2'd1;
            end
         end else begin
            tag_n      = cur.tag_len;
            need_open  = (cur.tag_len != 2'd0) && !cur.seg_open;
            need_close = (cur.tag_len != 2'd0) || cur.seg_open;
         end
         nxt = '0;
      end else if (cur.in_code) begin
         if (cur.held_q) begin
            if (data == CH_GT) begin
               ch_seg      = {8'h00, CH_LF};
               ch_n        = 2'd1;
               nxt.held_q  = 1'b0;
               nxt.in_code = 1'b0;
            end else if (data == CH_QM) begin
               ch_seg = {8'h00, CH_QM};
               ch_n   = 2'd1;
            end else begin
               ch_seg     = {data, CH_QM};
               ch_n       = 2'd2;
               nxt.held_q = 1'b0;
            end
         end else if (data == CH_QM) begin
            nxt.held_q = 1'b1;
         end else begin
            ch_seg = {8'h00, data};
            ch_n   = 2'd1;
         end
      end else if (data == tag_char(cur.tag_len)) begin
         if (cur.tag_len == 2'd3) begin
            // tag complete: close any open run and enter code
            need_close   = cur.seg_open;
            nxt.seg_open = 1'b0;
            nxt.in_code  = 1'b1;
            nxt.tag_len  = 2'd0;
            nxt.held_q   = 1'b0;
         end else begin
            nxt.tag_len = cur.tag_len + 2'd1;
         end
      end else begin
         // broken match: write the held prefix, then the byte unless it restarts
         tag_n     = cur.tag_len;
         need_open = !cur.seg_open && ((cur.tag_len != 2'd0) || !is_lt);
         if (!is_lt) begin
            case (data)
               CH_BSLASH: begin ch_seg = {CH_BSLASH, CH_BSLASH}; ch_n = 2'd2; end
               CH_DQUOTE: begin ch_seg = {CH_DQUOTE, CH_BSLASH}; ch_n = 2'd2; end
               CH_DOLLAR: begin ch_seg = {CH_DOLLAR, CH_BSLASH}; ch_n = 2'd2; end
               CH_LF:     begin ch_seg = {CH_N, CH_BSLASH};      ch_n = 2'd2; end
               CH_CR:     begin ch_seg = {CH_R, CH_BSLASH};      ch_n = 2'd2; end
               CH_TAB:    begin ch_seg = {CH_T, CH_BSLASH};      ch_n = 2'd2; end
               default:   begin ch_seg = {8'h00, data};          ch_n = 2'd1; end
            endcase
         end
         nxt.seg_open = cur.seg_open | need_open;
         nxt.tag_len  = is_lt ? 2'd1 : 2'd0;
      end

      // pack: wrapper open, held tag, byte, wrapper close
      acc = need_open ? BUF_W'(WRAP_OPEN) : '0;
      pos = need_open ? WRAP_OPEN_LEN : '0;
      acc = acc | (BUF_W'(tag_bytes(tag_n)) << {pos, 3'b000});
      pos = pos + CNT_W'(tag_n);
      acc = acc | (BUF_W'(ch_seg) << {pos, 3'b000});
      pos = pos + CNT_W'(ch_n);
      if (need_close) begin
         acc = acc | (BUF_W'(WRAP_CLOSE) << {pos, 3'b000});
         pos = pos + WRAP_CLOSE_LEN;
      end
      emit.bytes = acc;
      emit.count = pos;
   end

endmodule

// ===== rtl/core/template_block_translator_unit.sv =====
// Top level of the template block translator: request register, burst shifter.
// A taken request is registered, translated, and its burst loaded into the burst shifter.
// Throughput: one result byte per cycle while rsp_tready is high; a request producing
//   bytes occupies the burst shifter until they are sent; one producing none does not wait.
// The burst shifter is the limit: a new request enters as the previous burst ends.
// Reset (synchronous, active high) empties both stages and returns to text mode.
`timescale 1ns / 1ps

module template_block_translator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_req
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);
   import tbt_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_kind_ff;
   logic [7:0]           s1_byte_ff;
   tbt_state_type        state_ff, state_in;
   logic [BUF_W-1:0]     buf_ff, buf_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   tbt_emit_type         emit;
   logic                 buf_free;
   logic                 s1_advance;
   logic                 rsp_take;

   tbt_xlate u_xlate (
      .cur  (state_ff),
      .kind (s1_kind_ff),
      .data (s1_byte_ff),
      .nxt  (state_in),
      .emit (emit)
   );

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign buf_free   = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_tready);
   assign s1_advance = s1_valid_ff && ((emit.count == '0) || buf_free);
   assign req_tready = !s1_valid_ff || s1_advance;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = buf_ff[7:0];
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (s1_advance && (emit.count != '0)) begin
         buf_in = emit.bytes;
         cnt_in = emit.count;
      end else if (rsp_take) begin
         // advance to the next byte of the burst
         buf_in = buf_ff >> 8;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         state_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
         if (s1_advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
      buf_ff <= buf_in;
   end

endmodule

// ===== rtl/core/tbt_checker.sv =====
// Port-level checks for the template block translator, bound to the top level.
`timescale 1ns / 1ps

module tbt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while waiting");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // nothing is shown the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a burst runs without gaps up to its last byte
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a result burst");

   // a raw newline only ever ends a burst: wrapper close or code byte
   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == 8'h0A) |-> rsp_tlast)
      else $error("newline inside a result burst");

endmodule

bind template_block_translator_unit tbt_checker u_tbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
